FILE: rtl/core/ctqd_pkg.sv
// ----------------------------------------------------------------------------
// ctqd_pkg
// Shared types, constants and helpers for the CAN transmit mailbox dispatcher.
// ----------------------------------------------------------------------------
package ctqd_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int WORD_W          = 32;
    localparam int MBOX_NUM        = 3;
    localparam int MBOX_W          = 2;

    localparam logic [WORD_W-1:0] TXRQ_BIT = 32'h0000_0001;

    typedef enum logic {
        CMD_SEND  = 1'b0,
        CMD_EVENT = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] data_high;
        logic [WORD_W-1:0] data_low;
        logic [WORD_W-1:0] len_word;
        logic [WORD_W-1:0] id_word;
    } frame_t;

    function automatic logic [MBOX_W-1:0] lowest_free(input logic [MBOX_NUM-1:0] free_bits);
        logic [MBOX_W-1:0] idx;
        if (free_bits[0])
        begin
            idx = 2'd0;
        end
        else if (free_bits[1])
        begin
            idx = 2'd1;
        end
        else
        begin
            idx = 2'd2;
        end
        return idx;
    endfunction

endpackage

FILE: rtl/core/ctqd_if.sv
// ----------------------------------------------------------------------------
// ctqd_req_if / ctqd_rsp_if
// Valid/ready channels for dispatcher requests and mailbox results.
// ----------------------------------------------------------------------------
interface ctqd_req_if;
    logic                            valid;
    logic                            ready;
    ctqd_pkg::cmd_t                  cmd;
    logic [ctqd_pkg::MBOX_NUM-1:0]   mailbox_free;
    logic [ctqd_pkg::WORD_W-1:0]     frame_id_word;
    logic [ctqd_pkg::WORD_W-1:0]     frame_len_word;
    logic [ctqd_pkg::WORD_W-1:0]     frame_data_low;
    logic [ctqd_pkg::WORD_W-1:0]     frame_data_high;

    modport source (
        output valid, cmd, mailbox_free, frame_id_word, frame_len_word,
               frame_data_low, frame_data_high,
        input  ready
    );

    modport sink (
        input  valid, cmd, mailbox_free, frame_id_word, frame_len_word,
               frame_data_low, frame_data_high,
        output ready
    );
endinterface

interface ctqd_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            status;
    logic                            mailbox_write;
    logic [ctqd_pkg::MBOX_W-1:0]     mailbox_index;
    logic [ctqd_pkg::WORD_W-1:0]     out_id_word;
    logic [ctqd_pkg::WORD_W-1:0]     out_len_word;
    logic [ctqd_pkg::WORD_W-1:0]     out_data_low;
    logic [ctqd_pkg::WORD_W-1:0]     out_data_high;
    logic                            irq_enabled;
    logic                            clear_done_flags;

    modport source (
        output valid, status, mailbox_write, mailbox_index, out_id_word,
               out_len_word, out_data_low, out_data_high, irq_enabled,
               clear_done_flags,
        input  ready
    );

    modport sink (
        input  valid, status, mailbox_write, mailbox_index, out_id_word,
               out_len_word, out_data_low, out_data_high, irq_enabled,
               clear_done_flags,
        output ready
    );
endinterface

FILE: rtl/core/can_tx_queue_mailbox_dispatch.sv
// ----------------------------------------------------------------------------
// can_tx_queue_mailbox_dispatch
// Transmit scheduler for three CAN mailboxes with a ring queue of pending
// frames; direct writes, queueing, dequeue on mailbox-empty events.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  req     | in  | cmd, mailbox_free, four frame words
//  rsp     | out | status, mailbox write and words, irq_enabled, clear flags
//
//  One beat per cycle while rsp.ready keeps up; each result appears the cycle after its request.
//  The decision is taken against the queue state at acceptance; a queued
//  frame is read from the ring store in the same cycle into its read register.
//  req.ready drops only while a result is held with rsp.ready low.
//  Reset clears ring positions, fill count and interrupt enable; the store
//  is not cleared.
// ----------------------------------------------------------------------------
module can_tx_queue_mailbox_dispatch #(
    parameter int QUEUE_DEPTH = ctqd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ctqd_req_if.sink    req,
    ctqd_rsp_if.source  rsp
);
    import ctqd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic               irq_on_reg;

    logic               res_valid_reg;
    logic               status_reg;
    logic               write_reg;
    logic               from_store_reg;
    logic               clear_reg;
    logic [MBOX_W-1:0]  index_reg;
    frame_t             frame_reg;

    logic               accept;
    logic               is_send;
    logic               any_free;
    logic               ring_empty;
    logic               direct;
    logic               enq;
    logic               full;
    logic               deq;
    logic               clr;
    logic               irq_next;
    frame_t             in_frame;
    frame_t             store_rd;
    frame_t             src_frame;

    assign req.ready   = !res_valid_reg || rsp.ready;
    assign accept      = req.valid && req.ready;

    assign is_send     = (req.cmd == CMD_SEND);
    assign any_free    = |req.mailbox_free;
    assign ring_empty  = (fill_reg == '0);

    assign direct   = is_send && ring_empty && any_free;
    assign enq      = is_send && !direct && (fill_reg != CNT_FULL);
    assign full     = is_send && !direct && (fill_reg == CNT_FULL);
    assign deq      = !is_send && !ring_empty && any_free;
    assign clr      = !is_send && ring_empty;
    assign irq_next = is_send ? 1'b1 : (clr ? 1'b0 : irq_on_reg);

    assign in_frame = '{data_high: req.frame_data_high,
                        data_low:  req.frame_data_low,
                        len_word:  req.frame_len_word,
                        id_word:   req.frame_id_word};

    ctqd_store #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && enq),
        .wr_addr (wr_ptr_reg),
        .wr_data (in_frame),
        .rd_en   (accept && deq),
        .rd_addr (rd_ptr_reg),
        .rd_data (store_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            irq_on_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                res_valid_reg <= 1'b1;
                irq_on_reg    <= irq_next;
                if (enq)
                begin
                    wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                    fill_reg   <= fill_reg + 1'b1;
                end
                if (deq)
                begin
                    rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                    fill_reg   <= fill_reg - 1'b1;
                end
            end
            else if (rsp.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: hold while stalled.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= full;
            write_reg      <= direct || deq;
            from_store_reg <= deq;
            clear_reg      <= clr;
            index_reg      <= lowest_free(req.mailbox_free);
            frame_reg      <= in_frame;
        end
    end

    assign src_frame = from_store_reg ? store_rd : frame_reg;

    assign rsp.valid            = res_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.mailbox_write    = write_reg;
    assign rsp.mailbox_index    = write_reg ? index_reg : '0;
    assign rsp.out_id_word      = write_reg ? (src_frame.id_word | TXRQ_BIT) : '0;
    assign rsp.out_len_word     = write_reg ? src_frame.len_word : '0;
    assign rsp.out_data_low     = write_reg ? src_frame.data_low : '0;
    assign rsp.out_data_high    = write_reg ? src_frame.data_high : '0;
    assign rsp.irq_enabled      = irq_on_reg;
    assign rsp.clear_done_flags = clear_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_FULL)
        else $error("fill count above queue depth");

    a_ptr_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("ring positions differ with empty queue");

    a_send_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_send) |=> irq_on_reg)
        else $error("send left interrupt disabled");

    a_full_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && status_reg) |-> (!write_reg && !clear_reg))
        else $error("dropped frame also written or flags cleared");

    a_clear_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && clear_reg) |-> (!irq_on_reg && !write_reg))
        else $error("flag clear with interrupt on or mailbox write");

endmodule

FILE: rtl/core/ctqd_store.sv
// ----------------------------------------------------------------------------
// ctqd_store
// Pending frame ring storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ctqd_store #(
    parameter int DEPTH  = ctqd_pkg::QUEUE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  ctqd_pkg::frame_t    wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output ctqd_pkg::frame_t    rd_data
);
    import ctqd_pkg::*;

    frame_t mem [DEPTH];
    frame_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CAN transmit mailbox dispatcher. Send requests
// and mailbox-empty events are driven on the request channel with random
// gaps. A scoreboard keeps its own copy of the ring queue and the interrupt
// enable, and works out the mailbox write for each accepted beat. Results
// are taken with random back-pressure and compared field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ctqd_pkg::*;

    localparam int RING_DEPTH   = QUEUE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 2000;
    localparam int IDLE_LIMIT   = 1000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        cmd_t                cmd;
        logic [MBOX_NUM-1:0] free;
        frame_t              frame;
    } dispatch_req_t;

    typedef struct packed {
        logic              status;
        logic              mailbox_write;
        logic [MBOX_W-1:0] mailbox_index;
        logic [WORD_W-1:0] id_word;
        logic [WORD_W-1:0] len_word;
        logic [WORD_W-1:0] data_low;
        logic [WORD_W-1:0] data_high;
        logic              irq_enabled;
        logic              clear_done_flags;
    } dispatch_rsp_t;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } traffic_t;

    class mailbox_scoreboard;
        frame_t            ring [RING_DEPTH];
        int unsigned       wr_pos       = 0;
        int unsigned       rd_pos       = 0;
        int unsigned       fill         = 0;
        logic              irq_on       = 1'b0;
        dispatch_rsp_t     expected [$];
        int                mismatches   = 0;
        int                results_seen = 0;
        int                n_send       = 0;
        int                n_event      = 0;
        int                n_direct     = 0;
        int                n_queued     = 0;
        int                n_dropped    = 0;
        int                n_dequeued   = 0;
        int                n_cleared    = 0;
        int                n_blocked    = 0;
        int unsigned       peak_fill    = 0;

        function logic [MBOX_W-1:0] pick_mailbox(logic [MBOX_NUM-1:0] free);
            return free[0] ? 2'd0 : (free[1] ? 2'd1 : 2'd2);
        endfunction

        function dispatch_rsp_t mailbox_write(logic [MBOX_NUM-1:0] free, frame_t f);
            dispatch_rsp_t w;
            w               = '0;
            w.mailbox_write = 1'b1;
            w.mailbox_index = pick_mailbox(free);
            w.id_word       = f.id_word | TXRQ_BIT;
            w.len_word      = f.len_word;
            w.data_low      = f.data_low;
            w.data_high     = f.data_high;
            return w;
        endfunction

        function void note_request(dispatch_req_t r);
            dispatch_rsp_t e;
            e = '0;
            if (r.cmd == CMD_SEND)
            begin
                n_send++;
                if (fill == 0 && r.free != '0)
                begin
                    e = mailbox_write(r.free, r.frame);
                    n_direct++;
                end
                else if (fill < RING_DEPTH)
                begin
                    ring[wr_pos] = r.frame;
                    wr_pos       = (wr_pos + 1) % RING_DEPTH;
                    fill++;
                    n_queued++;
                    if (fill > peak_fill)
                    begin
                        peak_fill = fill;
                    end
                end
                else
                begin
                    e.status = 1'b1;
                    n_dropped++;
                end
                irq_on = 1'b1;
            end
            else
            begin
                n_event++;
                if (fill > 0)
                begin
                    if (r.free != '0)
                    begin
                        e      = mailbox_write(r.free, ring[rd_pos]);
                        rd_pos = (rd_pos + 1) % RING_DEPTH;
                        fill--;
                        n_dequeued++;
                    end
                    else
                    begin
                        n_blocked++;
                    end
                end
                else
                begin
                    e.clear_done_flags = 1'b1;
                    irq_on             = 1'b0;
                    n_cleared++;
                end
            end
            e.irq_enabled = irq_on;
            expected.push_back(e);
        endfunction

        function string describe(dispatch_rsp_t x);
            return $sformatf({"status=%0b wr=%0b idx=%0d id=%h len=%h dl=%h dh=%h",
                              " irq=%0b clr=%0b"},
                             x.status, x.mailbox_write, x.mailbox_index, x.id_word,
                             x.len_word, x.data_low, x.data_high, x.irq_enabled,
                             x.clear_done_flags);
        endfunction

        function void check_result(dispatch_rsp_t got);
            dispatch_rsp_t want;
            results_seen++;
            if (expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("result %0d arrived with nothing expected: %s",
                             results_seen, describe(got));
                end
                return;
            end
            want = expected.pop_front();
            if (got.status !== want.status || got.mailbox_write !== want.mailbox_write ||
                got.mailbox_index !== want.mailbox_index || got.id_word !== want.id_word ||
                got.len_word !== want.len_word || got.data_low !== want.data_low ||
                got.data_high !== want.data_high || got.irq_enabled !== want.irq_enabled ||
                got.clear_done_flags !== want.clear_done_flags)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("result %0d mismatch", results_seen);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    bit                src_calm;
    bit                snk_calm;
    int                idle_cycles;
    mailbox_scoreboard sb;

    ctqd_req_if req_bus ();
    ctqd_rsp_if rsp_bus ();

    can_tx_queue_mailbox_dispatch #(
        .QUEUE_DEPTH (RING_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic dispatch_req_t make_request(cmd_t cmd, logic [MBOX_NUM-1:0] free,
                                                   logic [WORD_W-1:0] id_word,
                                                   logic [WORD_W-1:0] len_word,
                                                   logic [WORD_W-1:0] data_low,
                                                   logic [WORD_W-1:0] data_high);
        dispatch_req_t r;
        r.cmd             = cmd;
        r.free            = free;
        r.frame.id_word   = id_word;
        r.frame.len_word  = len_word;
        r.frame.data_low  = data_low;
        r.frame.data_high = data_high;
        return r;
    endfunction

    function automatic dispatch_req_t random_request(traffic_t mode);
        dispatch_req_t r;
        int            send_pct;
        case (mode)
            MIX_FILL:  send_pct = 80;
            MIX_DRAIN: send_pct = 20;
            default:   send_pct = 50;
        endcase
        r.cmd  = ($urandom_range(0, 99) < send_pct) ? CMD_SEND : CMD_EVENT;
        r.free = ($urandom_range(0, 2) == 0) ? 3'b000 : 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0:       r.frame = '1;
            1:       r.frame = '0;
            default: r.frame = {$urandom, $urandom, $urandom, $urandom};
        endcase
        return r;
    endfunction

    task automatic drive_request(input dispatch_req_t r);
        int gap;
        if ($urandom_range(0, 31) == 0)
        begin
            src_calm = !src_calm;
        end
        gap = src_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid           <= 1'b1;
        req_bus.cmd             <= r.cmd;
        req_bus.mailbox_free    <= r.free;
        req_bus.frame_id_word   <= r.frame.id_word;
        req_bus.frame_len_word  <= r.frame.len_word;
        req_bus.frame_data_low  <= r.frame.data_low;
        req_bus.frame_data_high <= r.frame.data_high;
        do
        begin
            @(posedge clk);
        end
        while (!req_bus.ready);
        sb.note_request(r);
    endtask

    initial
    begin
        traffic_t mode;
        int       run_left;
        sb                      = new;
        req_bus.valid           <= 1'b0;
        req_bus.cmd             <= CMD_SEND;
        req_bus.mailbox_free    <= '0;
        req_bus.frame_id_word   <= '0;
        req_bus.frame_len_word  <= '0;
        req_bus.frame_data_low  <= '0;
        req_bus.frame_data_high <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // empty queue events, direct writes, queueing, blocked event, drain
        drive_request(make_request(CMD_EVENT, 3'b111, '1, '1, '1, '1));
        drive_request(make_request(CMD_EVENT, 3'b000, '0, '0, '0, '0));
        drive_request(make_request(CMD_SEND, 3'b001, '1, '1, '1, '1));
        drive_request(make_request(CMD_SEND, 3'b010, '0, '0, '0, '0));
        drive_request(make_request(CMD_SEND, 3'b100, 32'h1234_5678, 32'h0000_0008,
                                   32'hDEAD_BEEF, 32'hCAFE_F00D));
        drive_request(make_request(CMD_SEND, 3'b000, 32'hFFFF_FFFE, 32'h8000_0000,
                                   32'h5555_5555, 32'hAAAA_AAAA));
        drive_request(make_request(CMD_SEND, 3'b111, 32'h0000_0002, 32'h7FFF_FFFF,
                                   32'hAAAA_AAAA, 32'h5555_5555));
        drive_request(make_request(CMD_EVENT, 3'b000, '1, '1, '1, '1));
        drive_request(make_request(CMD_EVENT, 3'b110, '0, '0, '0, '0));
        drive_request(make_request(CMD_EVENT, 3'b011, '0, '0, '0, '0));
        drive_request(make_request(CMD_EVENT, 3'b101, '0, '0, '0, '0));
        // fill the ring, then overflow it with a mailbox free
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            drive_request(make_request(CMD_SEND, 3'b000, $urandom, $urandom, $urandom,
                                       $urandom));
        end
        drive_request(make_request(CMD_SEND, 3'b111, '1, '1, '1, '1));

        mode     = MIX_EVEN;
        run_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (run_left == 0)
            begin
                mode     = traffic_t'($urandom_range(0, 2));
                run_left = $urandom_range(8, 64);
            end
            run_left--;
            drive_request(random_request(mode));
        end
        req_bus.valid <= 1'b0;

        while (sb.expected.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);

        $display("Ran %0d sends and %0d mailbox-empty events: %0d direct, %0d queued, %0d dropped",
                 sb.n_send, sb.n_event, sb.n_direct, sb.n_queued, sb.n_dropped);
        $display("Dequeued %0d, cleared flags %0d, blocked events %0d, peak ring fill %0d",
                 sb.n_dequeued, sb.n_cleared, sb.n_blocked, sb.peak_fill);
        if (sb.mismatches == 0 && sb.expected.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("%0d mismatches, %0d results outstanding", sb.mismatches,
                     sb.expected.size());
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        int stall;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                snk_calm = !snk_calm;
            end
            stall = snk_calm ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!rsp_bus.valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            sb.check_result({rsp_bus.status, rsp_bus.mailbox_write, rsp_bus.mailbox_index,
                             rsp_bus.out_id_word, rsp_bus.out_len_word,
                             rsp_bus.out_data_low, rsp_bus.out_data_high,
                             rsp_bus.irq_enabled, rsp_bus.clear_done_flags});
        end
    end

    always @(posedge clk)
    begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with no beat", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

FILE: can_tx_queue_mailbox_dispatch.f
rtl/core/ctqd_pkg.sv
rtl/core/ctqd_if.sv
rtl/core/ctqd_store.sv
rtl/core/can_tx_queue_mailbox_dispatch.sv
sim/testbench.sv
